### hdl/aavr_pkg.sv
// Shared types, constants and tables for the axis-angle vector rotation core.
package aavr_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int ANG_SHIFT    = 29 - FRAC_BITS;
   localparam int NORM_STAGES  = 5;
   localparam int SQRT_STEPS   = 31;
   localparam int DIV_STEPS    = 32;
   localparam int CORDIC_STEPS = 30;

   localparam logic signed [33:0] GAIN_INV    = 34'sd652032874;
   localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [33:0] TWO_PI_Q30  = 34'sd6746518852;
   localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [29:0] OUT_MAX     = 30'sd8388607;
   localparam logic signed [29:0] OUT_MIN     = -30'sd8388608;

   typedef struct packed {
      logic signed [23:0] vec_x;
      logic signed [23:0] vec_y;
      logic signed [23:0] vec_z;
      logic signed [23:0] axis_x;
      logic signed [23:0] axis_y;
      logic signed [23:0] axis_z;
      logic signed [19:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [23:0] out_x;
      logic signed [23:0] out_y;
      logic signed [23:0] out_z;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] vec_x;
      logic signed [23:0] vec_y;
      logic signed [23:0] vec_z;
      logic [2:0][23:0]   amag;
      logic [2:0]         aneg;
      logic               zero;
      logic               neg;
      logic [4:0]         half_k;
      logic signed [33:0] h;
      logic signed [32:0] u_x;
      logic signed [32:0] u_y;
      logic signed [32:0] u_z;
   } ctx_type;

   typedef struct packed {
      logic [61:0] x;
      logic [32:0] rem;
      logic [30:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [30:0]       r;
      logic [2:0][30:0]  rem;
      logic [2:0][31:0]  low;
      logic [2:0][31:0]  quo;
   } div_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_type;

   function automatic logic signed [33:0] atan_lut(input logic [4:0] idx);
      logic signed [33:0] v;
      unique case (idx)
         5'd0:  v = 34'sd843314856;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043836;
         5'd3:  v = 34'sd133525158;
         5'd4:  v = 34'sd67021686;
         5'd5:  v = 34'sd33543515;
         5'd6:  v = 34'sd16775850;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194282;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048575;
         5'd11: v = 34'sd524287;
         5'd12: v = 34'sd262143;
         5'd13: v = 34'sd131071;
         5'd14: v = 34'sd65535;
         5'd15: v = 34'sd32767;
         5'd16: v = 34'sd16383;
         5'd17: v = 34'sd8191;
         5'd18: v = 34'sd4095;
         5'd19: v = 34'sd2047;
         5'd20: v = 34'sd1023;
         5'd21: v = 34'sd511;
         5'd22: v = 34'sd255;
         5'd23: v = 34'sd127;
         5'd24: v = 34'sd63;
         5'd25: v = 34'sd31;
         5'd26: v = 34'sd15;
         5'd27: v = 34'sd8;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

### hdl/aavr_prep.sv
// Front end: axis squares, angle range reduction and axis length normalization.
module aavr_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  aavr_pkg::req_type   in_req,
   output logic                out_valid,
   output aavr_pkg::ctx_type   out_ctx,
   output aavr_pkg::sqrt_type  out_sq
);

   logic signed [47:0] sqw_in [3];
   logic signed [23:0] axis_in [3];
   logic signed [33:0] hraw_in;
   logic signed [33:0] hred_in;
   aavr_pkg::ctx_type  actx_in;

   logic               a_valid_ff;
   aavr_pkg::ctx_type  actx_ff;
   logic [46:0]        sq_ff [3];

   logic [48:0]        len_in;
   aavr_pkg::ctx_type  bctx_in;

   logic               nvalid_ff [aavr_pkg::NORM_STAGES+1];
   aavr_pkg::ctx_type  nctx_ff [aavr_pkg::NORM_STAGES+1];
   logic [61:0]        nx_ff [aavr_pkg::NORM_STAGES+1];

   always_comb begin
      axis_in[0] = in_req.axis_x;
      axis_in[1] = in_req.axis_y;
      axis_in[2] = in_req.axis_z;
      actx_in = '0;
      actx_in.vec_x = in_req.vec_x;
      actx_in.vec_y = in_req.vec_y;
      actx_in.vec_z = in_req.vec_z;
      for (int j = 0; j < 3; j++) begin
         sqw_in[j] = axis_in[j] * axis_in[j];
         actx_in.aneg[j] = axis_in[j][23];
         actx_in.amag[j] = axis_in[j][23] ? (~axis_in[j] + 24'd1) : axis_in[j];
      end
      hraw_in = 34'(in_req.angle) <<< aavr_pkg::ANG_SHIFT;
      if (hraw_in > aavr_pkg::PI_Q30) begin
         hred_in = hraw_in - aavr_pkg::TWO_PI_Q30;
      end else if (hraw_in < -aavr_pkg::PI_Q30) begin
         hred_in = hraw_in + aavr_pkg::TWO_PI_Q30;
      end else begin
         hred_in = hraw_in;
      end
      actx_in.h = hred_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      actx_ff <= actx_in;
      for (int j = 0; j < 3; j++) begin
         sq_ff[j] <= sqw_in[j][46:0];
      end
   end

   always_comb begin
      len_in = {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
      bctx_in = actx_ff;
      bctx_in.zero = (len_in == '0);
      bctx_in.half_k = '0;
      if (actx_ff.h > aavr_pkg::HALF_PI_Q30) begin
         bctx_in.h = actx_ff.h - aavr_pkg::PI_Q30;
         bctx_in.neg = 1'b1;
      end else if (actx_ff.h < -aavr_pkg::HALF_PI_Q30) begin
         bctx_in.h = actx_ff.h + aavr_pkg::PI_Q30;
         bctx_in.neg = 1'b1;
      end else begin
         bctx_in.neg = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nvalid_ff[0] <= 1'b0;
      end else begin
         nvalid_ff[0] <= a_valid_ff;
      end
      nctx_ff[0] <= bctx_in;
      nx_ff[0] <= {13'd0, len_in};
   end

   for (genvar g = 0; g < aavr_pkg::NORM_STAGES; g++) begin : g_norm
      localparam int SH = 32 >> g;
      logic              shift_in;
      aavr_pkg::ctx_type ctx_in;
      logic [61:0]       x_in;

      always_comb begin
         shift_in = (nx_ff[g][61 -: SH] == '0);
         ctx_in = nctx_ff[g];
         x_in = nx_ff[g];
         if (shift_in) begin
            x_in = nx_ff[g] << SH;
            ctx_in.half_k = nctx_ff[g].half_k + 5'(SH / 2);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nvalid_ff[g+1] <= 1'b0;
         end else begin
            nvalid_ff[g+1] <= nvalid_ff[g];
         end
         nctx_ff[g+1] <= ctx_in;
         nx_ff[g+1] <= x_in;
      end
   end

   assign out_valid  = nvalid_ff[aavr_pkg::NORM_STAGES];
   assign out_ctx    = nctx_ff[aavr_pkg::NORM_STAGES];
   assign out_sq.x    = nx_ff[aavr_pkg::NORM_STAGES];
   assign out_sq.rem  = '0;
   assign out_sq.root = '0;

endmodule

### hdl/aavr_sqrt_cell.sv
// One digit step of the square root chain for the axis length.
module aavr_sqrt_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  aavr_pkg::ctx_type   in_ctx,
   input  aavr_pkg::sqrt_type  in_sq,
   output logic                out_valid,
   output aavr_pkg::ctx_type   out_ctx,
   output aavr_pkg::sqrt_type  out_sq
);

   logic [34:0]        acc_in;
   logic [34:0]        trial_in;
   logic               ge_in;
   aavr_pkg::sqrt_type sq_in;

   logic               valid_ff;
   aavr_pkg::ctx_type  ctx_ff;
   aavr_pkg::sqrt_type sq_ff;

   always_comb begin
      acc_in   = {in_sq.rem, in_sq.x[61:60]};
      trial_in = {2'b00, in_sq.root, 2'b01};
      ge_in    = (acc_in >= trial_in);
      sq_in.x    = {in_sq.x[59:0], 2'b00};
      sq_in.rem  = ge_in ? 33'(acc_in - trial_in) : acc_in[32:0];
      sq_in.root = {in_sq.root[29:0], ge_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      ctx_ff <= in_ctx;
      sq_ff  <= sq_in;
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;
   assign out_sq    = sq_ff;

endmodule

### hdl/aavr_div_cell.sv
// One quotient bit of the three-lane restoring divider for the unit axis.
module aavr_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  aavr_pkg::ctx_type  in_ctx,
   input  aavr_pkg::div_type  in_dv,
   output logic               out_valid,
   output aavr_pkg::ctx_type  out_ctx,
   output aavr_pkg::div_type  out_dv
);

   logic [31:0]       trial_in [3];
   logic              ge_in [3];
   aavr_pkg::div_type dv_in;

   logic              valid_ff;
   aavr_pkg::ctx_type ctx_ff;
   aavr_pkg::div_type dv_ff;

   always_comb begin
      dv_in = in_dv;
      for (int j = 0; j < 3; j++) begin
         trial_in[j] = {in_dv.rem[j], in_dv.low[j][31]};
         ge_in[j] = (trial_in[j] >= {1'b0, in_dv.r});
         dv_in.rem[j] = ge_in[j] ? 31'(trial_in[j] - {1'b0, in_dv.r}) : trial_in[j][30:0];
         dv_in.low[j] = {in_dv.low[j][30:0], 1'b0};
         dv_in.quo[j] = {in_dv.quo[j][30:0], ge_in[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      ctx_ff <= in_ctx;
      dv_ff  <= dv_in;
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;
   assign out_dv    = dv_ff;

endmodule

### hdl/aavr_cordic_cell.sv
// One rotation step of the sine and cosine chain.
module aavr_cordic_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [4:0]           step,
   input  logic                 in_valid,
   input  aavr_pkg::ctx_type    in_ctx,
   input  aavr_pkg::cordic_type in_cr,
   output logic                 out_valid,
   output aavr_pkg::ctx_type    out_ctx,
   output aavr_pkg::cordic_type out_cr
);

   logic signed [33:0]   dx_in;
   logic signed [33:0]   dy_in;
   logic signed [33:0]   ang_in;
   aavr_pkg::cordic_type cr_in;

   logic                 valid_ff;
   aavr_pkg::ctx_type    ctx_ff;
   aavr_pkg::cordic_type cr_ff;

   always_comb begin
      dx_in  = in_cr.y >>> step;
      dy_in  = in_cr.x >>> step;
      ang_in = aavr_pkg::atan_lut(step);
      if (!in_cr.z[33]) begin
         cr_in.x = in_cr.x - dx_in;
         cr_in.y = in_cr.y + dy_in;
         cr_in.z = in_cr.z - ang_in;
      end else begin
         cr_in.x = in_cr.x + dx_in;
         cr_in.y = in_cr.y - dy_in;
         cr_in.z = in_cr.z + ang_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      ctx_ff <= in_ctx;
      cr_ff  <= cr_in;
   end

   assign out_valid = valid_ff;
   assign out_ctx   = ctx_ff;
   assign out_cr    = cr_ff;

endmodule

### hdl/aavr_post.sv
// Back end: scaled axis, two cross products, sum, rounding and saturation.
module aavr_post (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  aavr_pkg::ctx_type    in_ctx,
   input  aavr_pkg::cordic_type in_cr,
   output logic                 out_valid,
   output aavr_pkg::rsp_type    out_rsp
);

   logic signed [33:0] sn_in;
   logic signed [33:0] cs_in;
   logic signed [32:0] u_in [3];
   logic signed [23:0] vin_in [3];

   logic               valid_ff [1:6];
   logic signed [23:0] vec_ff [1:6][3];
   logic signed [33:0] cs_ff [1:4];

   logic signed [66:0] prod_ff [3];
   logic signed [66:0] wr_in [3];
   logic signed [33:0] w_ff [3];
   logic signed [33:0] w3_ff [3];
   logic signed [33:0] w4_ff [3];

   logic signed [57:0] m_ff [6];
   logic signed [58:0] pd_in [3];
   logic signed [33:0] p_ff [3];

   logic signed [67:0] n_ff [6];
   logic signed [67:0] c_ff [3];
   logic signed [68:0] qd_in [3];
   logic signed [67:0] tr_in [3];
   logic signed [35:0] q_ff [3];
   logic signed [35:0] t_ff [3];

   logic signed [36:0] sum_in [3];
   logic signed [29:0] res_in [3];
   logic signed [23:0] out_in [3];

   logic               out_valid_ff;
   aavr_pkg::rsp_type  rsp_ff;

   always_comb begin
      sn_in = in_ctx.neg ? -in_cr.y : in_cr.y;
      cs_in = in_ctx.neg ? -in_cr.x : in_cr.x;
      u_in[0] = in_ctx.u_x;
      u_in[1] = in_ctx.u_y;
      u_in[2] = in_ctx.u_z;
      vin_in[0] = in_ctx.vec_x;
      vin_in[1] = in_ctx.vec_y;
      vin_in[2] = in_ctx.vec_z;
      for (int j = 0; j < 3; j++) begin
         wr_in[j] = prod_ff[j] + (67'sd1 <<< 29);
         pd_in[j] = 59'(m_ff[2*j]) - 59'(m_ff[2*j+1]) + (59'sd1 <<< 23);
         qd_in[j] = 69'(n_ff[2*j]) - 69'(n_ff[2*j+1]) + (69'sd1 <<< 28);
         tr_in[j] = c_ff[j] + (68'sd1 <<< 28);
         sum_in[j] = 37'(vec_ff[6][j]) * 37'sd64 + 37'(t_ff[j]) + 37'(q_ff[j]) + 37'sd32;
         res_in[j] = sum_in[j][35:6];
         if (res_in[j] > aavr_pkg::OUT_MAX) begin
            out_in[j] = aavr_pkg::OUT_MAX[23:0];
         end else if (res_in[j] < aavr_pkg::OUT_MIN) begin
            out_in[j] = aavr_pkg::OUT_MIN[23:0];
         end else begin
            out_in[j] = res_in[j][23:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 1; s <= 6; s++) begin
            valid_ff[s] <= 1'b0;
         end
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[1] <= in_valid;
         for (int s = 2; s <= 6; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
         out_valid_ff <= valid_ff[6];
      end
      for (int j = 0; j < 3; j++) begin
         vec_ff[1][j] <= vin_in[j];
         for (int s = 2; s <= 6; s++) begin
            vec_ff[s][j] <= vec_ff[s-1][j];
         end
      end
      cs_ff[1] <= cs_in;
      for (int s = 2; s <= 4; s++) begin
         cs_ff[s] <= cs_ff[s-1];
      end
      for (int j = 0; j < 3; j++) begin
         prod_ff[j] <= u_in[j] * sn_in;
         w_ff[j]  <= wr_in[j][63:30];
         w3_ff[j] <= w_ff[j];
         w4_ff[j] <= w3_ff[j];
         p_ff[j]  <= pd_in[j][57:24];
         c_ff[j]  <= cs_ff[4] * p_ff[j];
         q_ff[j]  <= qd_in[j][64:29];
         t_ff[j]  <= tr_in[j][64:29];
      end
      m_ff[0] <= w_ff[1] * vec_ff[2][2];
      m_ff[1] <= w_ff[2] * vec_ff[2][1];
      m_ff[2] <= w_ff[2] * vec_ff[2][0];
      m_ff[3] <= w_ff[0] * vec_ff[2][2];
      m_ff[4] <= w_ff[0] * vec_ff[2][1];
      m_ff[5] <= w_ff[1] * vec_ff[2][0];
      n_ff[0] <= w4_ff[1] * p_ff[2];
      n_ff[1] <= w4_ff[2] * p_ff[1];
      n_ff[2] <= w4_ff[2] * p_ff[0];
      n_ff[3] <= w4_ff[0] * p_ff[2];
      n_ff[4] <= w4_ff[0] * p_ff[1];
      n_ff[5] <= w4_ff[1] * p_ff[0];
      rsp_ff.out_x <= out_in[0];
      rsp_ff.out_y <= out_in[1];
      rsp_ff.out_z <= out_in[2];
   end

   assign out_valid = out_valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

### hdl/axis_angle_vector_rotate_core.sv
// Top level of the axis-angle vector rotation core.
// Rotates vec about axis by angle (all signed fixed point, 16 fraction bits)
// and returns the saturated rotated vector.
// Request channel: drive req_data and raise start for one cycle; the request
// is taken at the rising edge where start is high and busy is low. busy stays
// low, so a new request may be taken at every clock edge.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data; the
// receiver must take it in that cycle, there is no way to hold it off.
// Throughput is one request per cycle. The pipeline is a chain of
// registered cells: 7 front-end stages, 31 square root steps, 32 divider
// steps that each serve all three axis components, 30 rotation steps for
// sine and cosine, two setup stages and 6 back-end stages before the
// result register.
// Results come out in request order.
// Reset (synchronous, active high) clears every stage valid bit, so no result
// strobe follows from requests in flight; there is no other state to clear.
module axis_angle_vector_rotate_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  aavr_pkg::req_type  req_data,
   output logic               rsp_valid,
   output aavr_pkg::rsp_type  rsp_data
);

   localparam int NSQ = aavr_pkg::SQRT_STEPS;
   localparam int NDV = aavr_pkg::DIV_STEPS;
   localparam int NCR = aavr_pkg::CORDIC_STEPS;

   logic                 accept;

   logic                 sq_valid [NSQ+1];
   aavr_pkg::ctx_type    sq_ctx [NSQ+1];
   aavr_pkg::sqrt_type   sq_data [NSQ+1];

   logic                 dv_valid [NDV+1];
   aavr_pkg::ctx_type    dv_ctx [NDV+1];
   aavr_pkg::div_type    dv_data [NDV+1];

   logic                 cr_valid [NCR+1];
   aavr_pkg::ctx_type    cr_ctx [NCR+1];
   aavr_pkg::cordic_type cr_data [NCR+1];

   logic [85:0]          num_in [3];
   aavr_pkg::div_type    dvset_in;
   logic                 dvset_valid_ff;
   aavr_pkg::ctx_type    dvset_ctx_ff;
   aavr_pkg::div_type    dvset_ff;

   logic signed [32:0]   uq_in [3];
   logic signed [32:0]   u_in [3];
   aavr_pkg::ctx_type    crset_ctx_in;
   aavr_pkg::cordic_type crset_in;
   logic                 crset_valid_ff;
   aavr_pkg::ctx_type    crset_ctx_ff;
   aavr_pkg::cordic_type crset_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   aavr_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_req    (req_data),
      .out_valid (sq_valid[0]),
      .out_ctx   (sq_ctx[0]),
      .out_sq    (sq_data[0])
   );

   for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
      aavr_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_valid[g]),
         .in_ctx    (sq_ctx[g]),
         .in_sq     (sq_data[g]),
         .out_valid (sq_valid[g+1]),
         .out_ctx   (sq_ctx[g+1]),
         .out_sq    (sq_data[g+1])
      );
   end

   always_comb begin
      dvset_in.r = sq_data[NSQ].root;
      for (int j = 0; j < 3; j++) begin
         num_in[j] = ({62'd0, sq_ctx[NSQ].amag[j]} << (7'd30 + 7'(sq_ctx[NSQ].half_k)))
                   + {56'd0, sq_data[NSQ].root[30:1]};
         dvset_in.rem[j] = num_in[j][62:32];
         dvset_in.low[j] = num_in[j][31:0];
         dvset_in.quo[j] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvset_valid_ff <= 1'b0;
      end else begin
         dvset_valid_ff <= sq_valid[NSQ];
      end
      dvset_ctx_ff <= sq_ctx[NSQ];
      dvset_ff     <= dvset_in;
   end

   assign dv_valid[0] = dvset_valid_ff;
   assign dv_ctx[0]   = dvset_ctx_ff;
   assign dv_data[0]  = dvset_ff;

   for (genvar g = 0; g < NDV; g++) begin : g_div
      aavr_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[g]),
         .in_ctx    (dv_ctx[g]),
         .in_dv     (dv_data[g]),
         .out_valid (dv_valid[g+1]),
         .out_ctx   (dv_ctx[g+1]),
         .out_dv    (dv_data[g+1])
      );
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         uq_in[j] = {1'b0, dv_data[NDV].quo[j]};
         if (dv_ctx[NDV].zero) begin
            u_in[j] = '0;
         end else if (dv_ctx[NDV].aneg[j]) begin
            u_in[j] = -uq_in[j];
         end else begin
            u_in[j] = uq_in[j];
         end
      end
      crset_ctx_in = dv_ctx[NDV];
      crset_ctx_in.u_x = u_in[0];
      crset_ctx_in.u_y = u_in[1];
      crset_ctx_in.u_z = u_in[2];
      crset_in.x = aavr_pkg::GAIN_INV;
      crset_in.y = '0;
      crset_in.z = dv_ctx[NDV].h;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crset_valid_ff <= 1'b0;
      end else begin
         crset_valid_ff <= dv_valid[NDV];
      end
      crset_ctx_ff <= crset_ctx_in;
      crset_ff     <= crset_in;
   end

   assign cr_valid[0] = crset_valid_ff;
   assign cr_ctx[0]   = crset_ctx_ff;
   assign cr_data[0]  = crset_ff;

   for (genvar g = 0; g < NCR; g++) begin : g_cordic
      aavr_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (5'(g)),
         .in_valid  (cr_valid[g]),
         .in_ctx    (cr_ctx[g]),
         .in_cr     (cr_data[g]),
         .out_valid (cr_valid[g+1]),
         .out_ctx   (cr_ctx[g+1]),
         .out_cr    (cr_data[g+1])
      );
   end

   aavr_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cr_valid[NCR]),
      .in_ctx    (cr_ctx[NCR]),
      .in_cr     (cr_data[NCR]),
      .out_valid (rsp_valid),
      .out_rsp   (rsp_data)
   );

endmodule

### bench/tb.sv
// Testbench for the axis-angle vector rotation core: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

class rotation_scoreboard;
   aavr_pkg::rsp_type pending_rotations[$];
   int mismatches;
   int checked;

   function new();
      mismatches = 0;
      checked = 0;
   endfunction

   function void note_request(aavr_pkg::rsp_type expected);
      pending_rotations.push_back(expected);
   endfunction

   function int outstanding();
      return pending_rotations.size();
   endfunction

   task report_mismatch(string what, logic [23:0] got, logic [23:0] want);
      $display("mismatch %s: got %0d expected %0d", what,
               $signed(got), $signed(want));
      mismatches++;
   endtask

   task check_result(aavr_pkg::rsp_type got);
      aavr_pkg::rsp_type want;
      if (pending_rotations.size() == 0) begin
         $display("mismatch: result with no request outstanding");
         mismatches++;
         return;
      end
      want = pending_rotations.pop_front();
      checked++;
      if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
      if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
      if (got.out_z !== want.out_z) report_mismatch("out_z", got.out_z, want.out_z);
   endtask
endclass

module tb;

   localparam int LATENCY = 108;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_REQUESTS = 1500;

   typedef longint signed s64;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   aavr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   aavr_pkg::rsp_type rsp_data;

   rotation_scoreboard board = new();
   int idle_cycles = 0;
   int sent = 0;
   int zero_axis_sent = 0;
   int send_gap_pct = 0;

   axis_angle_vector_rotate_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   function automatic s64 shift_floor(s64 v, int s);
      return v >>> s;
   endfunction

   function automatic s64 round_half_up(s64 v, int s);
      return (v + (s64'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint unsigned sqrt_floor(longint unsigned x);
      longint unsigned root;
      longint unsigned bit_v;
      root = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
         if (x >= root + bit_v) begin
            x -= root + bit_v;
            root = (root >> 1) + bit_v;
         end else begin
            root >>= 1;
         end
         bit_v >>= 2;
      end
      return root;
   endfunction

   function automatic s64 arctan_step(int i);
      s64 t [30] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                     33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                     524287, 262143, 131071, 65535, 32767, 16383, 8191, 4095,
                     2047, 1023, 511, 255, 127, 63, 31, 15, 8, 4, 2};
      return t[i];
   endfunction

   function automatic s64 saturate_out(s64 v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic aavr_pkg::rsp_type rotate_vector(aavr_pkg::req_type r);
      s64 v [3];
      s64 a [3];
      s64 u [3];
      s64 w [3];
      s64 p [3];
      s64 q [3];
      s64 h, x, y, z, dx, dy, sn, cs, t, res;
      longint unsigned len2, root, mag, quo;
      int k;
      bit flip;
      aavr_pkg::rsp_type o;
      v[0] = r.vec_x; v[1] = r.vec_y; v[2] = r.vec_z;
      a[0] = r.axis_x; a[1] = r.axis_y; a[2] = r.axis_z;
      u = '{0, 0, 0};
      len2 = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      if (len2 != 0) begin
         k = 0;
         while (len2 < (64'd1 << 60)) begin
            len2 <<= 2;
            k += 2;
         end
         root = sqrt_floor(len2);
         for (int j = 0; j < 3; j++) begin
            mag = (a[j] < 0) ? -a[j] : a[j];
            quo = ((mag << (30 + k / 2)) + (root >> 1)) / root;
            u[j] = (a[j] < 0) ? -s64'(quo) : s64'(quo);
         end
      end
      h = s64'(r.angle) * (s64'(1) <<< (29 - aavr_pkg::FRAC_BITS));
      h = h % 64'sd6746518852;
      if (h > 64'sd3373259426) h -= 64'sd6746518852;
      if (h < -64'sd3373259426) h += 64'sd6746518852;
      flip = 1'b0;
      if (h > 64'sd1686629713) begin
         h -= 64'sd3373259426;
         flip = 1'b1;
      end else if (h < -64'sd1686629713) begin
         h += 64'sd3373259426;
         flip = 1'b1;
      end
      x = 652032874; y = 0; z = h;
      for (int i = 0; i < 30; i++) begin
         dx = shift_floor(y, i);
         dy = shift_floor(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_step(i);
         end else begin
            x += dx; y -= dy; z += arctan_step(i);
         end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
      for (int j = 0; j < 3; j++) w[j] = round_half_up(u[j] * sn, 30);
      p[0] = round_half_up(w[1] * v[2] - w[2] * v[1], 24);
      p[1] = round_half_up(w[2] * v[0] - w[0] * v[2], 24);
      p[2] = round_half_up(w[0] * v[1] - w[1] * v[0], 24);
      q[0] = round_half_up(w[1] * p[2] - w[2] * p[1], 29);
      q[1] = round_half_up(w[2] * p[0] - w[0] * p[2], 29);
      q[2] = round_half_up(w[0] * p[1] - w[1] * p[0], 29);
      for (int j = 0; j < 3; j++) begin
         t = round_half_up(cs * p[j], 29);
         res = saturate_out(round_half_up(v[j] * 64 + t + q[j], 6));
         if (j == 0) o.out_x = res[23:0];
         else if (j == 1) o.out_y = res[23:0];
         else o.out_z = res[23:0];
      end
      return o;
   endfunction

   function automatic logic [23:0] random_component();
      case ($urandom_range(0, 5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($signed($urandom_range(0, 131072)) - 65536);
         3: return 24'($signed($urandom_range(0, 2048)) - 1024);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic aavr_pkg::req_type random_request();
      aavr_pkg::req_type r;
      r.vec_x = random_component();
      r.vec_y = random_component();
      r.vec_z = random_component();
      case ($urandom_range(0, 9))
         0: begin
            r.axis_x = '0; r.axis_y = '0; r.axis_z = '0;
         end
         1: begin
            r.axis_x = 24'($urandom_range(0, 3)) - 24'd1;
            r.axis_y = 24'($urandom_range(0, 2));
            r.axis_z = '0;
         end
         default: begin
            r.axis_x = random_component();
            r.axis_y = random_component();
            r.axis_z = random_component();
         end
      endcase
      r.angle = 20'($urandom);
      return r;
   endfunction

   function automatic aavr_pkg::req_type make_request(int vx, int vy, int vz,
                                                      int ax, int ay, int az, int ang);
      aavr_pkg::req_type r;
      r.vec_x = 24'(vx); r.vec_y = 24'(vy); r.vec_z = 24'(vz);
      r.axis_x = 24'(ax); r.axis_y = 24'(ay); r.axis_z = 24'(az);
      r.angle = 20'(ang);
      return r;
   endfunction

   task send_request(aavr_pkg::req_type r);
      while (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(rotate_vector(r));
      if (r.axis_x == 0 && r.axis_y == 0 && r.axis_z == 0) zero_axis_sent++;
      sent++;
   endtask

   task drain_results();
      start <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_request(65536, 0, 0, 0, 0, 65536, 102944));
      send_request(make_request(65536, 131072, -65536, 0, 0, 0, 100000));
      send_request(make_request(8388607, 8388607, 8388607, 65536, 65536, 0, 205887));
      send_request(make_request(-8388608, -8388608, -8388608, 1, 1, 1, 150000));
      send_request(make_request(8388607, -8388608, 0, 8388607, 8388607, 8388607,
                                524287));
      send_request(make_request(-8388608, 8388607, 4096, -8388608, -8388608,
                                -8388608, -524288));
      send_request(make_request(65536, 65536, 65536, 0, 65536, 0, 0));
      send_request(make_request(65536, 0, 0, 0, 1, 0, 205887));
      send_request(make_request(65536, 0, 0, 0, 0, -1, -205887));
      send_request(make_request(0, 65536, 0, 65536, 0, 0, 411775));
      send_request(make_request(0, 0, 65536, 3, 4, 12, 300000));
      send_request(make_request(0, 0, 0, 65536, 65536, 65536, 77777));
      send_request(make_request(-1, 1, -1, -65536, 0, 65536, 51472));
      send_request(make_request(5000000, -5000000, 7000000, 1, -1, 0, 170000));
      send_request(make_request(123456, -654321, 8000000, 0, 0, 0, -524288));
      send_request(make_request(65536, 65536, 0, 8388607, 0, 0, -102944));
      send_request(make_request(65536, 0, 65536, 0, -8388608, 0, 480000));
      drain_results();

      for (int phase = 0; phase < 3; phase++) begin
         send_gap_pct = (phase == 0) ? 22 : (phase == 1) ? 67 : 0;
         for (int n = 0; n < RANDOM_REQUESTS / 3; n++) begin
            send_request(random_request());
         end
         drain_results();
      end

      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d requests, %0d with a zero axis, %0d results checked",
               sent, zero_axis_sent, board.checked);
      $display("sender gaps of 22, 67 and 0 percent, with full drains between phases");
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

### sim.f
hdl/aavr_pkg.sv
hdl/aavr_prep.sv
hdl/aavr_sqrt_cell.sv
hdl/aavr_div_cell.sv
hdl/aavr_cordic_cell.sv
hdl/aavr_post.sv
hdl/axis_angle_vector_rotate_core.sv
bench/tb.sv
